/* hdl/led_matrix_framebuffer_serializer_top_assert.svh */
// assertion macros for the led matrix frame buffer serialiser
`ifndef LED_MATRIX_FRAMEBUFFER_SERIALIZER_TOP_ASSERT_SVH
`define LED_MATRIX_FRAMEBUFFER_SERIALIZER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// property that must hold on every clock edge out of reset
`define LMFB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lmfb assertion failed");
// consequent must hold in the cycle after the antecedent
`define LMFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lmfb assertion failed");
`else
`define LMFB_ASSERT(lbl, prop)
`define LMFB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/lmfb_pkg.sv */
// shared types, constants and tables of the led matrix frame buffer serialiser
`timescale 1ns / 1ps
`default_nettype none
package lmfb_pkg;

  localparam int MODULES    = 4;
  localparam int ROWS       = 8;
  localparam int ROW_W      = 3;
  localparam int MOD_W      = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int DEPTH      = MODULES * ROWS;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int INIT_STEPS = 5;
  localparam int STEP_W     = 3;

  localparam logic [3:0] ADDR_DIGIT0    = 4'h1;
  localparam logic [3:0] ADDR_DECODE    = 4'h9;
  localparam logic [3:0] ADDR_INTENSITY = 4'hA;
  localparam logic [3:0] ADDR_SCANLIMIT = 4'hB;
  localparam logic [3:0] ADDR_SHUTDOWN  = 4'hC;
  localparam logic [3:0] ADDR_TEST      = 4'hF;

  localparam logic [7:0] MAX_BRIGHT = 8'd15;

  typedef enum logic [2:0] {
    REQ_PIXEL  = 3'd0,
    REQ_CLEAR  = 3'd1,
    REQ_UPDATE = 3'd2,
    REQ_BRIGHT = 3'd3,
    REQ_INIT   = 3'd4
  } req_e;

  typedef struct packed {
    req_e             op;
    logic [IDX_W-1:0] idx;
    logic [7:0]       mask;
    logic             on;
    logic             pix_ok;
    logic [3:0]       bright;
  } cmd_t;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       rel;
    logic       last;
  } word_t;

  // setup sequence sent by init, one broadcast per step
  function automatic logic [3:0] init_addr(input logic [STEP_W-1:0] step);
    logic [3:0] a;
    unique case (step)
      3'd0:    a = ADDR_SHUTDOWN;
      3'd1:    a = ADDR_DECODE;
      3'd2:    a = ADDR_SCANLIMIT;
      3'd3:    a = ADDR_TEST;
      3'd4:    a = ADDR_INTENSITY;
      default: a = ADDR_INTENSITY;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] init_data(input logic [STEP_W-1:0] step);
    logic [7:0] d;
    unique case (step)
      3'd0:    d = 8'h01;
      3'd1:    d = 8'h00;
      3'd2:    d = 8'h07;
      3'd3:    d = 8'h00;
      3'd4:    d = 8'h04;
      default: d = 8'h00;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* hdl/lmfb_front.sv */
// request decoder: bounds check, pixel mapping and brightness clamp
`timescale 1ns / 1ps
`default_nettype none
module lmfb_front import lmfb_pkg::*; (
  input  wire logic        in_valid_i,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [15:0] pixel_x_i,
  input  wire logic [15:0] pixel_y_i,
  input  wire logic        pixel_on_i,
  input  wire logic [7:0]  brightness_i,
  input  wire logic        q_full_i,
  output logic             in_stall_o,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic             code_ok;
  logic             x_ok;
  logic             y_ok;
  logic [MOD_W-1:0] col_mod;

  assign code_ok = (req_type_i <= REQ_INIT);
  // sign bit clear and below the display width
  assign x_ok = !pixel_x_i[15] && (pixel_x_i < 16'(DEPTH));
  assign y_ok = (pixel_y_i[15:ROW_W] == '0);
  // modules are numbered right to left
  assign col_mod = MOD_W'(MODULES - 1) - pixel_x_i[MOD_W+2:3];

  always_comb begin
    cmd_o.op     = req_e'(req_type_i);
    cmd_o.idx    = IDX_W'({col_mod, pixel_y_i[ROW_W-1:0]});
    cmd_o.mask   = 8'h80 >> pixel_x_i[2:0];
    cmd_o.on     = pixel_on_i;
    cmd_o.pix_ok = x_ok && y_ok;
    cmd_o.bright = (brightness_i > MAX_BRIGHT) ? 4'(MAX_BRIGHT) : brightness_i[3:0];
  end

  assign in_stall_o = q_full_i;
  // unused request codes are dropped here
  assign push_o     = in_valid_i && !q_full_i && code_ok;

endmodule
`default_nettype wire

/* hdl/lmfb_queue.sv */
// short command queue between decoder and sequencer
`timescale 1ns / 1ps
`default_nettype none
module lmfb_queue import lmfb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      full_o,
  output logic      empty_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

/* hdl/lmfb_back.sv */
// sequencer: frame buffer, word generation and output register
`timescale 1ns / 1ps
`default_nettype none
module lmfb_back import lmfb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire logic q_empty_i,
  output logic      pop_o,
  input  wire logic out_stall_i,
  output logic      out_valid_o,
  output word_t     word_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_BCAST = 3'b010,
    ST_FRAME = 3'b100
  } state_e;

  localparam logic [MOD_W-1:0] MOD_MAX = MOD_W'(MODULES - 1);

  state_e            state_q, state_d;
  logic [MOD_W-1:0]  mod_q, mod_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              init_q, init_d;
  logic [3:0]        bc_addr_q, bc_addr_d;
  logic [7:0]        bc_data_q, bc_data_d;
  logic [7:0]        store_q [DEPTH];
  logic [7:0]        store_d [DEPTH];
  logic              out_valid_q, out_valid_d;
  word_t             word_q, word_d;
  logic              adv;
  logic [IDX_W-1:0]  rd_idx;

  assign adv    = !out_valid_q || !out_stall_i;
  assign rd_idx = IDX_W'({mod_q, row_q});

  always_comb begin
    state_d     = state_q;
    mod_d       = mod_q;
    row_d       = row_q;
    step_d      = step_q;
    init_d      = init_q;
    bc_addr_d   = bc_addr_q;
    bc_data_d   = bc_data_q;
    store_d     = store_q;
    out_valid_d = out_valid_q && out_stall_i;
    word_d      = word_q;
    pop_o       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            REQ_PIXEL: begin
              if (cmd_i.pix_ok) begin
                store_d[cmd_i.idx] = cmd_i.on ? (store_q[cmd_i.idx] | cmd_i.mask)
                                              : (store_q[cmd_i.idx] & ~cmd_i.mask);
              end
            end
            REQ_CLEAR: begin
              for (int i = 0; i < DEPTH; i++) store_d[i] = '0;
            end
            REQ_UPDATE: begin
              state_d = ST_FRAME;
              row_d   = '0;
              mod_d   = MOD_MAX;
            end
            REQ_BRIGHT: begin
              state_d   = ST_BCAST;
              init_d    = 1'b0;
              mod_d     = MOD_MAX;
              bc_addr_d = ADDR_INTENSITY;
              bc_data_d = {4'b0, cmd_i.bright};
            end
            REQ_INIT: begin
              state_d   = ST_BCAST;
              init_d    = 1'b1;
              step_d    = '0;
              mod_d     = MOD_MAX;
              bc_addr_d = init_addr('0);
              bc_data_d = init_data('0);
            end
            default: ;
          endcase
        end
      end
      ST_BCAST: begin
        if (adv) begin
          out_valid_d = 1'b1;
          word_d.addr = bc_addr_q;
          word_d.data = bc_data_q;
          word_d.rel  = (mod_q == '0);
          word_d.last = (mod_q == '0) && !init_q;
          if (mod_q == '0) begin
            mod_d = MOD_MAX;
            if (!init_q) begin
              state_d = ST_IDLE;
            end else if (step_q == STEP_W'(INIT_STEPS - 1)) begin
              // setup done: clear the buffer, then send the blank frame
              for (int i = 0; i < DEPTH; i++) store_d[i] = '0;
              state_d = ST_FRAME;
              row_d   = '0;
            end else begin
              step_d    = step_q + 1'b1;
              bc_addr_d = init_addr(step_q + 1'b1);
              bc_data_d = init_data(step_q + 1'b1);
            end
          end else begin
            mod_d = mod_q - 1'b1;
          end
        end
      end
      ST_FRAME: begin
        if (adv) begin
          out_valid_d = 1'b1;
          word_d.addr = ADDR_DIGIT0 + {1'b0, row_q};
          word_d.data = store_q[rd_idx];
          word_d.rel  = (mod_q == '0);
          word_d.last = (mod_q == '0) && (row_q == ROW_W'(ROWS - 1));
          if (mod_q == '0) begin
            mod_d = MOD_MAX;
            row_d = row_q + 1'b1;
            if (row_q == ROW_W'(ROWS - 1)) begin
              state_d = ST_IDLE;
            end
          end else begin
            mod_d = mod_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mod_q       <= '0;
      row_q       <= '0;
      step_q      <= '0;
      init_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DEPTH; i++) store_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      mod_q       <= mod_d;
      row_q       <= row_d;
      step_q      <= step_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
      store_q     <= store_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bc_addr_q <= bc_addr_d;
    bc_data_q <= bc_data_d;
    word_q    <= word_d;
  end

  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;

endmodule
`default_nettype wire

/* hdl/led_matrix_framebuffer_serializer_top.sv */
// an accepted item is written into the queue; the sequencer pops it from the head when
// idle, and its first word passes the state register, then the output register. words
// leave at one per cycle while the receiver does not stall, set by the single-word
// output register. a two-entry queue lets items arrive while words drain.
// reset (rst_ni low, asynchronous) empties the queue, idles the sequencer, drops any
// pending word and zeroes the whole frame buffer at once.
`timescale 1ns / 1ps
`default_nettype none
`include "led_matrix_framebuffer_serializer_top_assert.svh"
module led_matrix_framebuffer_serializer_top import lmfb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [15:0] pixel_x_i,
  input  wire logic [15:0] pixel_y_i,
  input  wire logic        pixel_on_i,
  input  wire logic [7:0]  brightness_i,
  // serial word channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       reg_addr_o,
  output logic [7:0]       reg_data_o,
  output logic             select_release_o,
  output logic             last_o
);

  // decoded request on its way into the queue
  cmd_t  push_cmd;
  logic  push;
  // head of the queue as seen by the sequencer
  cmd_t  head_cmd;
  logic  q_full;
  logic  q_empty;
  logic  pop;
  word_t word;

  // front: bounds check and classification of each item
  lmfb_front u_front (
    .in_valid_i   (in_valid_i),
    .req_type_i   (req_type_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .pixel_on_i   (pixel_on_i),
    .brightness_i (brightness_i),
    .q_full_i     (q_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // decoupling queue, so up to two items can be accepted while a frame drains
  lmfb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: frame buffer and word sequencer, in request order
  lmfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .word_o      (word)
  );

  assign reg_addr_o       = word.addr;
  assign reg_data_o       = word.data;
  assign select_release_o = word.rel;
  assign last_o           = word.last;

  // the closing word of a request always ends a chip-select group
  `LMFB_ASSERT(a_last_releases, !out_valid_o || !last_o || select_release_o)
  // register address zero is never sent
  `LMFB_ASSERT(a_addr_nonzero, !out_valid_o || (reg_addr_o != 4'h0))
  // inside a group words follow without a gap
  `LMFB_ASSERT_NEXT(a_group_unbroken,
                    out_valid_o && !out_stall_i && !select_release_o, out_valid_o)

endmodule
`default_nettype wire

/* sim/lmfb_checker.sv */
// checker for the led matrix frame buffer serialiser: predicts serial words and compares them
`timescale 1ns / 1ps
module lmfb_checker import lmfb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] pixel_x_i,
  input  logic [15:0] pixel_y_i,
  input  logic        pixel_on_i,
  input  logic [7:0]  brightness_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  reg_addr_i,
  input  logic [7:0]  reg_data_i,
  input  logic        select_release_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          words_pending_o
);

  localparam int MAX_SHOWN = 10;

  // setup broadcasts of init, entry 0 goes out first
  localparam logic [INIT_STEPS-1:0][3:0] SETUP_ADDR =
    {ADDR_INTENSITY, ADDR_TEST, ADDR_SCANLIMIT, ADDR_DECODE, ADDR_SHUTDOWN};
  localparam logic [INIT_STEPS-1:0][7:0] SETUP_DATA =
    {8'h04, 8'h00, 8'h07, 8'h00, 8'h01};

  logic [7:0] frame_rows [DEPTH];
  word_t      words_due [$];
  int         fails;

  function automatic void clear_frame();
    foreach (frame_rows[i]) frame_rows[i] = '0;
  endfunction

  function automatic void queue_word(input logic [3:0] a, input logic [7:0] d,
                                     input logic rel);
    word_t w;
    w.addr = a;
    w.data = d;
    w.rel  = rel;
    w.last = 1'b0;
    words_due.push_back(w);
  endfunction

  function automatic void broadcast(input logic [3:0] a, input logic [7:0] d);
    for (int m = 0; m < MODULES; m++) queue_word(a, d, m == MODULES - 1);
  endfunction

  // every row, highest module first, select released after module 0
  function automatic void queue_frame();
    for (int row = 0; row < ROWS; row++)
      for (int m = MODULES - 1; m >= 0; m--)
        queue_word(ADDR_DIGIT0 + 4'(row), frame_rows[m * ROWS + row], m == 0);
  endfunction

  function automatic void predict_request(input logic [2:0] req, input logic [15:0] x,
                                          input logic [15:0] y, input logic on,
                                          input logic [7:0] br);
    int                 due_start;
    int                 col;
    int                 idx;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [7:0]         mask;
    word_t              tail;
    due_start = words_due.size();
    sx = x;
    sy = y;
    case (req)
      REQ_PIXEL: begin
        if (sx >= 0 && sx < MODULES * 8 && sy >= 0 && sy < ROWS) begin
          col  = int'(sx);
          idx  = (MODULES - 1 - col / 8) * ROWS + int'(sy);
          mask = 8'h80 >> (col % 8);
          if (on) frame_rows[idx] = frame_rows[idx] | mask;
          else    frame_rows[idx] = frame_rows[idx] & ~mask;
        end
      end
      REQ_CLEAR:  clear_frame();
      REQ_UPDATE: queue_frame();
      REQ_BRIGHT: broadcast(ADDR_INTENSITY, (br > MAX_BRIGHT) ? MAX_BRIGHT : br);
      REQ_INIT: begin
        for (int s = 0; s < INIT_STEPS; s++) broadcast(SETUP_ADDR[s], SETUP_DATA[s]);
        clear_frame();
        queue_frame();
      end
      default: ;
    endcase
    if (words_due.size() > due_start) begin
      tail = words_due.pop_back();
      tail.last = 1'b1;
      words_due.push_back(tail);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    word_t got;
    word_t want;
    if (!rst_ni) begin
      clear_frame();
      words_due.delete();
      fails = 0;
      fail_count_o    <= 0;
      words_pending_o <= 0;
    end else begin
      // outputs first: a word never stems from an item taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        got.addr = reg_addr_i;
        got.data = reg_data_i;
        got.rel  = select_release_i;
        got.last = last_i;
        if (words_due.size() == 0) begin
          if (fails < MAX_SHOWN)
            $display("unexpected word at %0t: addr %h data %h rel %b last %b",
                     $time, got.addr, got.data, got.rel, got.last);
          fails++;
        end else begin
          want = words_due.pop_front();
          if (got.addr !== want.addr || got.data !== want.data ||
              got.rel !== want.rel || got.last !== want.last) begin
            if (fails < MAX_SHOWN)
              $display("mismatch at %0t: expected addr %h data %h rel %b last %b, %s",
                       $time, want.addr, want.data, want.rel, want.last,
                       $sformatf("got addr %h data %h rel %b last %b",
                                 got.addr, got.data, got.rel, got.last));
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_request(req_type_i, pixel_x_i, pixel_y_i, pixel_on_i, brightness_i);
      fail_count_o    <= fails;
      words_pending_o <= words_due.size();
    end
  end

endmodule

/* sim/testbench.sv */
// top of the led matrix frame buffer serialiser bench: stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module testbench;
  import lmfb_pkg::*;

  // idling phases of the run
  typedef enum logic [2:0] {
    PH_NONE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_HOLD
  } phase_e;

  // request codes the block does not know, expected to be ignored
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  localparam int RANDOM_PER_PHASE = 108;
  localparam int HOLD_ITEMS       = 24;
  localparam int HOLD_CYCLES      = 400;
  localparam int SETTLE_CYCLES    = 64;
  localparam int DRAIN_LIMIT      = 200000;
  localparam int TIMEOUT_NS       = 60_000_000;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [2:0]  req_type_i   = REQ_UPDATE;
  logic [15:0] pixel_x_i    = '0;
  logic [15:0] pixel_y_i    = '0;
  logic        pixel_on_i   = 1'b0;
  logic [7:0]  brightness_i = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [3:0]  reg_addr_o;
  logic [7:0]  reg_data_o;
  logic        select_release_o;
  logic        last_o;

  int          fail_count;
  int          words_pending;
  phase_e      phase        = PH_BOTH;
  int          hold_count   = 0;

  led_matrix_framebuffer_serializer_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .pixel_x_i        (pixel_x_i),
    .pixel_y_i        (pixel_y_i),
    .pixel_on_i       (pixel_on_i),
    .brightness_i     (brightness_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .reg_addr_o       (reg_addr_o),
    .reg_data_o       (reg_data_o),
    .select_release_o (select_release_o),
    .last_o           (last_o)
  );

  // watches both channels, predicts every word and counts mismatches
  lmfb_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .req_type_i       (req_type_i),
    .pixel_x_i        (pixel_x_i),
    .pixel_y_i        (pixel_y_i),
    .pixel_on_i       (pixel_on_i),
    .brightness_i     (brightness_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .reg_addr_i       (reg_addr_o),
    .reg_data_i       (reg_data_o),
    .select_release_i (select_release_o),
    .last_i           (last_o),
    .fail_count_o     (fail_count),
    .words_pending_o  (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #TIMEOUT_NS;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver side: one long hold-off when the hold phase opens, random stalls in the receiver-stall and both phases
  always @(posedge clk_i) begin
    if (phase == PH_HOLD && hold_count < HOLD_CYCLES) begin
      out_stall_i <= 1'b1;
      hold_count  <= hold_count + 1;
    end else begin
      case (phase)
        PH_RECV_STALL: out_stall_i <= ($urandom_range(0, 99) < 83);
        PH_BOTH:       out_stall_i <= ($urandom_range(0, 99) < 23);
        default:       out_stall_i <= 1'b0;
      endcase
    end
  end

  // offer one item, idling first as the phase asks, and return at the accepting edge
  task automatic offer(input logic [2:0] req, input logic [15:0] x, input logic [15:0] y,
                       input logic on, input logic [7:0] br);
    int idle_pct;
    case (phase)
      PH_SEND_IDLE: idle_pct = 83;
      PH_BOTH:      idle_pct = 23;
      default:      idle_pct = 0;
    endcase
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    pixel_x_i    <= x;
    pixel_y_i    <= y;
    pixel_on_i   <= on;
    brightness_i <= br;
    @(posedge clk_i);
    // stall is read before this edge's updates land, so it is the value the block used
    while (in_stall_o) @(posedge clk_i);
  endtask

  // mostly well-formed drawing traffic, with some off-display pixels and spare codes
  task automatic offer_random();
    int          pick;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [7:0]  rb;
    logic        ron;
    pick = $urandom_range(0, 99);
    rx   = 16'($urandom());
    ry   = 16'($urandom());
    rb   = 8'($urandom());
    ron  = ($urandom_range(0, 9) < 7);
    if (pick < 56)
      offer(REQ_PIXEL, 16'($urandom_range(0, MODULES * 8 - 1)),
            16'($urandom_range(0, ROWS - 1)), ron, rb);
    else if (pick < 62)
      offer(REQ_PIXEL, rx, ry, ron, rb);
    else if (pick < 65)
      // column on the display but row just beyond it
      offer(REQ_PIXEL, 16'($urandom_range(0, MODULES * 8 - 1)),
            16'($urandom_range(ROWS, ROWS + 3)), ron, rb);
    else if (pick < 77)
      offer(REQ_UPDATE, rx, ry, ron, rb);
    else if (pick < 86)
      offer(REQ_BRIGHT, rx, ry, ron, rb);
    else if (pick < 91)
      offer(REQ_CLEAR, rx, ry, ron, rb);
    else if (pick < 96)
      offer(REQ_INIT, rx, ry, ron, rb);
    else
      offer(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), rx, ry, ron, rb);
  endtask

  // let every expected word come out, then switch the idling phase
  task automatic start_phase(input phase_e next);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    phase <= next;
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: init, pixel corners and module edges, off-display pixels
    offer(REQ_INIT, 16'($urandom()), 16'($urandom()), 1'b1, 8'($urandom()));
    offer(REQ_PIXEL, 16'd0, 16'd0, 1'b1, 8'hFF);
    offer(REQ_PIXEL, 16'(MODULES * 8 - 1), 16'(ROWS - 1), 1'b1, 8'h00);
    offer(REQ_PIXEL, 16'd7, 16'd3, 1'b1, 8'h00);
    offer(REQ_PIXEL, 16'd8, 16'd3, 1'b1, 8'h00);
    offer(REQ_PIXEL, 16'hFFFF, 16'd2, 1'b1, 8'h00);
    offer(REQ_PIXEL, 16'(MODULES * 8), 16'd2, 1'b1, 8'h00);
    offer(REQ_PIXEL, 16'd5, 16'(ROWS), 1'b1, 8'h00);
    offer(REQ_PIXEL, 16'h8000, 16'h8000, 1'b1, 8'h00);
    offer(REQ_PIXEL, 16'h7FFF, 16'h7FFF, 1'b1, 8'h00);
    offer(REQ_PIXEL, 16'd5, 16'hFFFF, 1'b1, 8'h00);
    offer(REQ_UPDATE, 16'($urandom()), 16'($urandom()), 1'b0, 8'($urandom()));
    // darken pixels that are lit
    offer(REQ_PIXEL, 16'd0, 16'd0, 1'b0, 8'h00);
    offer(REQ_PIXEL, 16'(MODULES * 8 - 1), 16'(ROWS - 1), 1'b0, 8'h00);
    offer(REQ_UPDATE, 16'h0000, 16'h0000, 1'b1, 8'h00);
    // brightness around the clamp
    offer(REQ_BRIGHT, 16'($urandom()), 16'($urandom()), 1'b0, 8'd0);
    offer(REQ_BRIGHT, 16'($urandom()), 16'($urandom()), 1'b1, MAX_BRIGHT);
    offer(REQ_BRIGHT, 16'($urandom()), 16'($urandom()), 1'b0, MAX_BRIGHT + 8'd1);
    offer(REQ_BRIGHT, 16'($urandom()), 16'($urandom()), 1'b1, 8'hFF);
    offer(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
    offer(REQ_UPDATE, 16'($urandom()), 16'($urandom()), 1'b1, 8'($urandom()));
    // spare request codes should leave no trace
    for (int c = REQ_SPARE_LO; c <= REQ_SPARE_HI; c++)
      offer(3'(c), 16'($urandom()), 16'($urandom()), 1'b1, 8'($urandom()));
    offer(REQ_UPDATE, 16'($urandom()), 16'($urandom()), 1'b0, 8'($urandom()));

    // random part, one block of items per idling phase, drained in between
    for (int p = PH_NONE; p <= PH_BOTH; p++) begin
      start_phase(phase_e'(p));
      repeat (RANDOM_PER_PHASE) offer_random();
    end

    // long receiver hold-off while the sender keeps offering, so the input stalls
    start_phase(PH_HOLD);
    offer(REQ_UPDATE, 16'($urandom()), 16'($urandom()), 1'b1, 8'($urandom()));
    repeat (HOLD_ITEMS) offer_random();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (words_pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    // give a stray word a chance to show
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && words_pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/lmfb_pkg.sv
hdl/lmfb_front.sv
hdl/lmfb_queue.sv
hdl/lmfb_back.sv
hdl/led_matrix_framebuffer_serializer_top.sv
sim/lmfb_checker.sv
sim/testbench.sv
